// ----- hw/rtl/tea_enc_pkg.sv -----
// ----------------------------------------------------------------------------
// tea_enc_pkg: shared types and constants of the tea block encrypt unit
// Holds the round constant, register indexes, the word-pair type and the
// half-round mixing function.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_enc_pkg;

  // word and config index widths
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // default number of full rounds
  localparam int unsigned ROUND_COUNT_DEF = 32;

  // golden-ratio round constant
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 2'd3;

  // half pair carried along the cell chain: p is updated, q feeds the mix
  typedef struct packed {
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] q;
  } half_pair_t;

  // shift, add and xor mixing of one half
  function automatic logic [WORD_W-1:0] mix_half(
    input logic [WORD_W-1:0] h,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = (h << 4) + ka;
    b = h + sum;
    c = (h >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tea_enc_cell.sv -----
// ----------------------------------------------------------------------------
// tea_enc_cell: one half-round cell of the encrypt chain
// Adds the mix of q to p and hands the pair on swapped, so the next cell
// updates the other half. Advances whenever the chain enable is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_enc_cell #(
  parameter logic [tea_enc_pkg::WORD_W-1:0] SUM = tea_enc_pkg::TEA_DELTA
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire tea_enc_pkg::half_pair_t         in_pair,
  input  wire logic [tea_enc_pkg::WORD_W-1:0]  ka,
  input  wire logic [tea_enc_pkg::WORD_W-1:0]  kb,
  output logic                                 out_valid,
  output tea_enc_pkg::half_pair_t              out_pair
);

  logic                    valid_r;
  tea_enc_pkg::half_pair_t pair_r;
  tea_enc_pkg::half_pair_t pair_nxt;

  // updated half moves to q, untouched half to p
  always_comb begin
    pair_nxt.p = in_pair.q;
    pair_nxt.q = in_pair.p + tea_enc_pkg::mix_half(in_pair.q, SUM, ka, kb);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // word pair
  always_ff @(posedge clk) begin
    if (en) begin
      pair_r <= pair_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pair  = pair_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tea_block_encrypt_unit.sv -----
// throughput: one block per cycle while the skid register is empty, through the chain of 2*ROUND_COUNT half-round cells
// a skid register behind the output register lets the chain stop after the output has stalled
// reset: synchronous active-low; clears all key words, cell valid bits and output state
// ----------------------------------------------------------------------------
// tea_block_encrypt_unit: tea block encryption, one block per cycle unless stalled
// Key words are held in a small register file written over the cfg port;
// each block runs through a row of half-round cells into an output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_encrypt_unit #(
  parameter int unsigned ROUND_COUNT = tea_enc_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration port
  input  wire logic                               cfg_we,
  input  wire logic [tea_enc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tea_enc_pkg::WORD_W-1:0]     cfg_wdata,
  // input word
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tea_enc_pkg::WORD_W-1:0]     in_block_low,
  input  wire logic [tea_enc_pkg::WORD_W-1:0]     in_block_high,
  // output word
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [tea_enc_pkg::WORD_W-1:0]          out_cipher_low,
  output logic [tea_enc_pkg::WORD_W-1:0]          out_cipher_high
);

  localparam int unsigned CellCount = 2 * ROUND_COUNT;

  logic [tea_enc_pkg::WORD_W-1:0] key_word0_r;
  logic [tea_enc_pkg::WORD_W-1:0] key_word1_r;
  logic [tea_enc_pkg::WORD_W-1:0] key_word2_r;
  logic [tea_enc_pkg::WORD_W-1:0] key_word3_r;

  logic                    chain_en;
  logic                    chain_valid [CellCount+1];
  tea_enc_pkg::half_pair_t chain_pair  [CellCount+1];

  logic                    out_valid_r;
  tea_enc_pkg::half_pair_t out_pair_r;
  logic                    skid_valid_r;
  tea_enc_pkg::half_pair_t skid_pair_r;

  // key register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word0_r <= '0;
      key_word1_r <= '0;
      key_word2_r <= '0;
      key_word3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tea_enc_pkg::REG_KEY_WORD0: key_word0_r <= cfg_wdata;
        tea_enc_pkg::REG_KEY_WORD1: key_word1_r <= cfg_wdata;
        tea_enc_pkg::REG_KEY_WORD2: key_word2_r <= cfg_wdata;
        tea_enc_pkg::REG_KEY_WORD3: key_word3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // chain moves while the skid register is empty
  assign chain_en = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // head of the chain
  assign chain_valid[0]  = in_valid;
  assign chain_pair[0].p = in_block_low;
  assign chain_pair[0].q = in_block_high;

  // half-round cells: even cells update the low half, odd cells the high half
  for (genvar i = 0; i < CellCount; i++) begin : g_cell
    localparam logic [63:0] SumWide =
      64'(tea_enc_pkg::TEA_DELTA) * 64'(i / 2 + 1);

    tea_enc_cell #(
      .SUM (SumWide[tea_enc_pkg::WORD_W-1:0])
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (chain_en),
      .in_valid  (chain_valid[i]),
      .in_pair   (chain_pair[i]),
      .ka        ((i % 2 == 0) ? key_word0_r : key_word2_r),
      .kb        ((i % 2 == 0) ? key_word1_r : key_word3_r),
      .out_valid (chain_valid[i+1]),
      .out_pair  (chain_pair[i+1])
    );
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        out_pair_r   <= skid_pair_r;
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && out_stall) begin
      if (chain_valid[CellCount]) begin
        skid_pair_r  <= chain_pair[CellCount];
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r <= chain_valid[CellCount];
      out_pair_r  <= chain_pair[CellCount];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cipher_low  = out_pair_r.p;
  assign out_cipher_high = out_pair_r.q;

endmodule

`default_nettype wire

// ----- dv/tb_tea_block_encrypt_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tea_block_encrypt_unit: self-checking bench for the tea encrypt unit
// Streams plaintext words through the unit under a series of keys, predicts
// every cipher word with a behavioural tea model and checks the output words
// in order, with input gaps, output stalls and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_tea_block_encrypt_unit;

  localparam int unsigned WORD_W       = tea_enc_pkg::WORD_W;
  localparam int unsigned CFG_IDX_W    = tea_enc_pkg::CFG_IDX_W;
  localparam int unsigned NUM_ROUNDS   = tea_enc_pkg::ROUND_COUNT_DEF;
  localparam int unsigned PIPE_LATENCY = 2 * NUM_ROUNDS + 1;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } cipher_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_block_low;
  logic [WORD_W-1:0]    in_block_high;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    out_cipher_low;
  logic [WORD_W-1:0]    out_cipher_high;

  // bench-side copy of the key and the cipher words still owed
  logic [WORD_W-1:0] key_copy [4];
  cipher_word_t      expected_cipher_q [$];

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned stuck_cycles  = 0;
  int unsigned err_count     = 0;
  int unsigned blocks_sent   = 0;
  int unsigned words_checked = 0;
  int unsigned key_loads     = 0;

  tea_block_encrypt_unit #(
    .ROUND_COUNT(NUM_ROUNDS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_block_low   (in_block_low),
    .in_block_high  (in_block_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cipher_low (out_cipher_low),
    .out_cipher_high(out_cipher_high)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // tea encryption of one block under the current key copy
  function automatic cipher_word_t predict_cipher(input logic [WORD_W-1:0] lo,
                                                  input logic [WORD_W-1:0] hi);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] s;
    cipher_word_t      res;
    y = lo;
    z = hi;
    s = '0;
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      s = s + 32'h9e37_79b9;
      y = y + ((((z << 4) + key_copy[0]) ^ (z + s)) ^ ((z >> 5) + key_copy[1]));
      z = z + ((((y << 4) + key_copy[2]) ^ (y + s)) ^ ((y >> 5) + key_copy[3]));
    end
    res.lo = y;
    res.hi = z;
    return res;
  endfunction

  // random word biased towards the extremes
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'h1 << $urandom_range(0, WORD_W - 1);
      3:       w = ~(32'h1 << $urandom_range(0, WORD_W - 1));
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // output checking and output back-pressure
  always @(posedge clk) begin : rx_check
    cipher_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cipher_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("ERROR: output word lo %h hi %h with no block outstanding",
                   out_cipher_low, out_cipher_high);
      end else begin
        want = expected_cipher_q.pop_front();
        words_checked++;
        if (out_cipher_low !== want.lo || out_cipher_high !== want.hi) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("ERROR: cipher word %0d expected lo %h hi %h, got lo %h hi %h",
                     words_checked, want.lo, want.hi, out_cipher_low, out_cipher_high);
        end
      end
    end
    // a new hold-off request starts a long stall counted here
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", STUCK_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one plaintext word, after a random gap, and note its cipher word
  task automatic send_block(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      in_block_low  <= $urandom();
      in_block_high <= $urandom();
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_block_low  <= lo;
    in_block_high <= hi;
    do @(posedge clk); while (in_stall);
    expected_cipher_q.push_back(predict_cipher(lo, hi));
    blocks_sent++;
  endtask

  // stop sending and wait until every cipher word is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_cipher_q.size() != 0);
  endtask

  // single key register write, caller lowers the enable
  task automatic put_key_word(input logic [CFG_IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    key_copy[idx] = val;
  endtask

  task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    put_key_word(tea_enc_pkg::REG_KEY_WORD0, k0);
    put_key_word(tea_enc_pkg::REG_KEY_WORD1, k1);
    put_key_word(tea_enc_pkg::REG_KEY_WORD2, k2);
    put_key_word(tea_enc_pkg::REG_KEY_WORD3, k3);
    cfg_we <= 1'b0;
    key_loads++;
  endtask

  // drain, take a fresh random key and set the gap rates
  task automatic start_phase(input int send_pct, input int rx_pct);
    wait_drain();
    load_key(pick_word(), pick_word(), pick_word(), pick_word());
    send_idle_pct = send_pct;
    stall_pct    <= rx_pct;
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_block(pick_word(), pick_word());
  endtask

  // reset key of zero with corner plaintexts
  task automatic test_zero_key_corners();
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, '0);
    send_block('0, '1);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    send_block(32'h5555_5555, 32'haaaa_aaaa);
    send_block(32'haaaa_aaaa, 32'h5555_5555);
    send_block(32'h0123_4567, 32'h89ab_cdef);
  endtask

  // extreme keys, a single-word key change and an explicit zero key
  task automatic test_key_extremes();
    wait_drain();
    load_key('1, '1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(32'hdead_beef, 32'h0bad_f00d);
    send_block(32'h7fff_ffff, 32'h8000_0000);
    wait_drain();
    load_key(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    send_block('0, '1);
    send_block(32'h1234_5678, 32'h9abc_def0);
    send_block('1, '0);
    wait_drain();
    put_key_word(tea_enc_pkg::REG_KEY_WORD2, 32'h8000_0001);
    cfg_we <= 1'b0;
    send_block('0, '0);
    send_block(32'h1234_5678, 32'h9abc_def0);
    wait_drain();
    load_key('0, '0, '0, '0);
    send_block(32'hffff_0000, 32'h0000_ffff);
  endtask

  task automatic test_streaming();
    start_phase(0, 0);
    send_random(150);
  endtask

  task automatic test_sender_gaps();
    start_phase(47, 0);
    send_random(120);
  endtask

  task automatic test_receiver_stalls();
    start_phase(0, 47);
    send_random(120);
  endtask

  // gaps on both sides, with a full pause of the sender half way
  task automatic test_mixed_gaps();
    start_phase(19, 19);
    send_random(60);
    wait_drain();
    send_random(60);
  endtask

  // long output hold-off while words keep coming, so the input backs up
  task automatic test_output_holdoff();
    start_phase(0, 0);
    hold_req <= hold_req + 1;
    send_random(100);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = tea_enc_pkg::REG_KEY_WORD0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_block_low  = '0;
    in_block_high = '0;
    out_stall     = 1'b0;
    for (int i = 0; i < 4; i++)
      key_copy[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_key_corners();
    test_key_extremes();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_output_holdoff();

    // let any stray output word show up
    wait_drain();
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    $display("Encrypted %0d blocks under %0d key loads, %0d cipher words checked,",
             blocks_sent, key_loads, words_checked);
    $display("with input gaps, output stalls and a %0d cycle output hold-off",
             HOLD_CYCLES);
    if (err_count == 0 && expected_cipher_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d errors, %0d cipher words never arrived",
               err_count, expected_cipher_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- tea_block_encrypt_unit.f -----
hw/rtl/tea_enc_pkg.sv
hw/rtl/tea_enc_cell.sv
hw/rtl/tea_block_encrypt_unit.sv
dv/tb_tea_block_encrypt_unit.sv
